// File: src/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types, character codes and helpers for the framed link receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

    // Link control characters.
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ETB = 8'h17;

    // Saturation value of the bad frame counter.
    localparam logic [3:0] BAD_COUNT_MAX = 4'd15;

    // Configuration register indexes.
    localparam logic CFG_RETRY_LIMIT  = 1'b0;
    localparam logic CFG_MAX_TEXT_LEN = 1'b1;

    // Configuration reset values.
    localparam logic [3:0] RETRY_LIMIT_RST  = 4'd7;
    localparam logic [7:0] MAX_TEXT_LEN_RST = 8'd240;

    typedef enum logic [2:0] {
        KIND_TEXT      = 3'd0,
        KIND_REPLY     = 3'd1,
        KIND_GOOD      = 3'd2,
        KIND_BAD       = 3'd3,
        KIND_MSG_END   = 3'd4,
        KIND_ABORT     = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_ACK  = 2'd1,
        REPLY_NAK  = 2'd2
    } t_reply;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text_byte;
        t_reply      reply_code;
        logic [7:0]  frame_digit;
        logic        final_frame;
        logic [7:0]  sum_computed;
    } t_result;

    // Uppercase hex digit decode: bit 4 is set when the byte is a valid digit,
    // bits 3:0 carry its value (zero for a non-digit).
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// File: src/afr_step.sv
// ----------------------------------------------------------------------------
// afr_step
// Link and frame state machine; decides the result caused by one byte.
// ----------------------------------------------------------------------------
module afr_step
    import afr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic [3:0]  i_retry_limit,
    input  logic [7:0]  i_max_text_len,
    output logic        o_res_valid,
    output t_result     o_res
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_WAIT_STX = 3'd1,
        PH_FNUM     = 3'd2,
        PH_TEXT     = 3'd3,
        PH_CK_HI    = 3'd4,
        PH_CK_LO    = 3'd5,
        PH_CR       = 3'd6,
        PH_LF       = 3'd7
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_sum,    n_sum;
    logic [7:0]  r_fnum,   n_fnum;
    logic        r_etx,    n_etx;
    logic [7:0]  r_count,  n_count;
    logic [3:0]  r_hi,     n_hi;
    logic        r_fault,  n_fault;
    logic [3:0]  r_bad,    n_bad;

    logic [4:0]  hex;
    logic [3:0]  bad_inc;
    logic        fault_lf;
    t_result     res;
    logic        res_valid;

    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_fnum    = r_fnum;
        n_etx     = r_etx;
        n_count   = r_count;
        n_hi      = r_hi;
        n_fault   = r_fault;
        n_bad     = r_bad;
        hex       = hex_decode(i_byte);
        bad_inc   = (r_bad < BAD_COUNT_MAX) ? 4'(r_bad + 4'd1) : r_bad;
        fault_lf  = r_fault || (i_byte != CH_LF);
        res_valid = 1'b0;
        res       = '{kind: KIND_TEXT, text_byte: 8'd0, reply_code: REPLY_NONE,
                      frame_digit: 8'd0, final_frame: 1'b0, sum_computed: 8'd0};

        case (r_phase)
            PH_IDLE: begin
                res_valid = 1'b1;
                res.kind  = KIND_REPLY;
                if (i_byte == CH_ENQ) begin
                    n_phase        = PH_WAIT_STX;
                    n_bad          = 4'd0;
                    res.reply_code = REPLY_ACK;
                end else begin
                    res.reply_code = REPLY_NAK;
                end
            end
            PH_WAIT_STX: begin
                if (i_byte == CH_STX) begin
                    n_phase = PH_FNUM;
                    n_sum   = 8'd0;
                    n_count = 8'd0;
                    n_fault = 1'b0;
                    n_hi    = 4'd0;
                    n_etx   = 1'b0;
                end else if (i_byte == CH_EOT) begin
                    n_phase   = PH_IDLE;
                    res_valid = 1'b1;
                    res.kind  = KIND_MSG_END;
                end
            end
            PH_FNUM: begin
                n_fnum  = i_byte;
                n_sum   = 8'(r_sum + i_byte);
                n_phase = PH_TEXT;
            end
            PH_TEXT: begin
                n_sum = 8'(r_sum + i_byte);
                if (i_byte == CH_ETX || i_byte == CH_ETB) begin
                    n_etx   = (i_byte == CH_ETX);
                    n_phase = PH_CK_HI;
                end else if (r_count >= i_max_text_len) begin
                    // Overlong text still enters the checksum but is dropped.
                    n_fault = 1'b1;
                end else begin
                    n_count       = 8'(r_count + 8'd1);
                    res_valid     = 1'b1;
                    res.kind      = KIND_TEXT;
                    res.text_byte = i_byte;
                end
            end
            PH_CK_HI: begin
                n_hi    = hex[3:0];
                n_fault = r_fault || !hex[4];
                n_phase = PH_CK_LO;
            end
            PH_CK_LO: begin
                n_fault = r_fault || !hex[4] || ({r_hi, hex[3:0]} != r_sum);
                n_phase = PH_CR;
            end
            PH_CR: begin
                n_fault = r_fault || (i_byte != CH_CR);
                n_phase = PH_LF;
            end
            PH_LF: begin
                n_fault          = fault_lf;
                res_valid        = 1'b1;
                res.frame_digit  = r_fnum;
                res.final_frame  = r_etx;
                res.sum_computed = r_sum;
                if (!fault_lf) begin
                    n_bad          = 4'd0;
                    n_phase        = PH_WAIT_STX;
                    res.kind       = KIND_GOOD;
                    res.reply_code = REPLY_ACK;
                end else if (bad_inc >= i_retry_limit) begin
                    // A limit of zero behaves as one, since the count is at least one here.
                    n_bad          = 4'd0;
                    n_phase        = PH_IDLE;
                    res.kind       = KIND_ABORT;
                    res.reply_code = REPLY_NAK;
                end else begin
                    n_bad          = bad_inc;
                    n_phase        = PH_WAIT_STX;
                    res.kind       = KIND_BAD;
                    res.reply_code = REPLY_NAK;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sum   <= 8'd0;
            r_fnum  <= 8'd0;
            r_etx   <= 1'b0;
            r_count <= 8'd0;
            r_hi    <= 4'd0;
            r_fault <= 1'b0;
            r_bad   <= 4'd0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_fnum  <= n_fnum;
            r_etx   <= n_etx;
            r_count <= n_count;
            r_hi    <= n_hi;
            r_fault <= n_fault;
            r_bad   <= n_bad;
        end
    end

    assign o_res_valid = i_valid && res_valid;
    assign o_res       = res;

endmodule

// File: src/afr_out_reg.sv
// ----------------------------------------------------------------------------
// afr_out_reg
// Result register that holds one item until the downstream side takes it.
// ----------------------------------------------------------------------------
module afr_out_reg
    import afr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    input  t_result     i_res,
    input  logic        i_ready,
    output logic        o_free,
    output logic        o_valid,
    output t_result     o_res
);

    logic    r_valid;
    t_result r_res;

    // The register can be loaded when empty or when its item leaves this cycle.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: src/astm_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// astm_frame_receiver_unit
// Receiving side of a framed ASCII serial link, one received byte per item.
// ----------------------------------------------------------------------------
// Path: each accepted byte waits in the input register, is stepped by the state
// machine and leaves its result in the result register for the master side.
// Throughput: one byte per cycle while the result register is free, set by the
// combinational state step between the input register and the result register.
// Reset: synchronous, active low; the link returns to idle, the bad frame
// count clears, and the registers return to a retry limit of 7 and 240 bytes.
// ----------------------------------------------------------------------------
module astm_frame_receiver_unit
    import afr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // Received bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] text_byte, [9:8] reply_code,
                                        // [17:10] frame_digit, [18] final_frame,
                                        // [26:19] sum_computed, [31:27] zero
    output logic [2:0]  m_axis_tuser    // [2:0] result_kind
);

    logic [3:0] r_retry_limit;
    logic [7:0] r_max_text_len;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       out_free;
    logic       step_valid;
    logic       res_valid;
    t_result    res;
    logic       out_valid;
    t_result    out_res;

    // Configuration registers; a write lands at any edge with the enable high,
    // so they should only be changed while no item is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit  <= RETRY_LIMIT_RST;
            r_max_text_len <= MAX_TEXT_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RETRY_LIMIT:  r_retry_limit  <= i_cfg_data[3:0];
                CFG_MAX_TEXT_LEN: r_max_text_len <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held byte is processed in the cycle the result register can take
    // whatever it produces, so the input register refills in that same cycle.
    assign s_axis_tready = !r_in_valid || out_free;
    assign step_valid    = r_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    afr_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (step_valid),
        .i_byte         (r_in_byte),
        .i_retry_limit  (r_retry_limit),
        .i_max_text_len (r_max_text_len),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    afr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_axis_tready),
        .o_free      (out_free),
        .o_valid     (out_valid),
        .o_res       (out_res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_res.kind;
    assign m_axis_tdata  = {5'd0, out_res.sum_computed, out_res.final_frame,
                            out_res.frame_digit, out_res.reply_code, out_res.text_byte};

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed link receiver.
// Bytes go in on the slave stream one item at a time, and a bit-exact model
// of the link state machine predicts the replies, text bytes and verdicts.
// Each result item from the master stream is matched field by field against
// the oldest prediction. The run starts with directed link, frame, text limit,
// retry and backpressure cases, then sends random sessions under several
// idle and stall mixes and register settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned LATENCY_WAIT  = 4;    // two pipeline stages plus slack
    localparam int unsigned MAX_GAP       = 40;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_ITEMS  = 70;   // per random phase

    // Link phases as the receiver walks through a session.
    typedef enum logic [2:0] {
        LP_IDLE, LP_WAIT_STX, LP_FNUM, LP_TEXT, LP_CK_HI, LP_CK_LO, LP_CR, LP_LF
    } t_link_phase;

    // Ways a frame can be spoiled on purpose.
    typedef enum int {
        FLAW_NONE, FLAW_SUM, FLAW_DIGIT_HI, FLAW_DIGIT_LO, FLAW_CR, FLAW_LF
    } t_frame_flaw;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = 1'b0;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] text_byte, [9:8] reply_code,
                                         // [17:10] frame_digit, [18] final_frame,
                                         // [26:19] sum_computed, [31:27] zero
    logic [2:0]  m_axis_tuser;           // [2:0] result_kind

    astm_frame_receiver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the link state and the registers.
    // ------------------------------------------------------------------------
    logic [3:0]  retry_limit    = RETRY_LIMIT_RST;
    logic [7:0]  max_text_len   = MAX_TEXT_LEN_RST;
    t_link_phase rx_phase       = LP_IDLE;
    logic [7:0]  rx_sum         = 8'd0;
    logic [7:0]  rx_frame_num   = 8'd0;
    logic        rx_ended_etx   = 1'b0;
    logic [7:0]  rx_text_count  = 8'd0;
    logic [3:0]  rx_high_nibble = 4'd0;
    logic        rx_fault       = 1'b0;
    logic [3:0]  rx_bad_frames  = 4'd0;

    t_result     awaited_results[$];
    int unsigned errors      = 0;
    int unsigned bytes_sent  = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned hold_left   = 0;

    // Value of an uppercase hex digit, or -1 for any other byte.
    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
    endfunction

    function automatic void queue_result(input t_kind kind, input logic [7:0] text,
                                         input t_reply reply, input logic [7:0] fnum,
                                         input logic fin, input logic [7:0] sum);
        t_result r;
        r.kind         = kind;
        r.text_byte    = text;
        r.reply_code   = reply;
        r.frame_digit  = fnum;
        r.final_frame  = fin;
        r.sum_computed = sum;
        awaited_results.push_back(r);
    endfunction

    // One received byte through the link state machine. Any result it causes
    // is appended to the queue of awaited results.
    function automatic void predict_link_step(input logic [7:0] b);
        int v;
        case (rx_phase)
            LP_IDLE: begin
                if (b == CH_ENQ) begin
                    rx_phase      = LP_WAIT_STX;
                    rx_bad_frames = 4'd0;
                    queue_result(KIND_REPLY, 8'd0, REPLY_ACK, 8'd0, 1'b0, 8'd0);
                end else begin
                    queue_result(KIND_REPLY, 8'd0, REPLY_NAK, 8'd0, 1'b0, 8'd0);
                end
            end
            LP_WAIT_STX: begin
                // Anything but STX or EOT is line noise here and is dropped.
                if (b == CH_STX) begin
                    rx_phase       = LP_FNUM;
                    rx_sum         = 8'd0;
                    rx_text_count  = 8'd0;
                    rx_fault       = 1'b0;
                    rx_high_nibble = 4'd0;
                    rx_ended_etx   = 1'b0;
                end else if (b == CH_EOT) begin
                    rx_phase = LP_IDLE;
                    queue_result(KIND_MSG_END, 8'd0, REPLY_NONE, 8'd0, 1'b0, 8'd0);
                end
            end
            LP_FNUM: begin
                rx_frame_num = b;
                rx_sum       = rx_sum + b;
                rx_phase     = LP_TEXT;
            end
            LP_TEXT: begin
                rx_sum = rx_sum + b;
                if (b == CH_ETX || b == CH_ETB) begin
                    rx_ended_etx = (b == CH_ETX);
                    rx_phase     = LP_CK_HI;
                end else if (rx_text_count >= max_text_len) begin
                    // Text beyond the limit is summed but swallowed.
                    rx_fault = 1'b1;
                end else begin
                    rx_text_count = rx_text_count + 8'd1;
                    queue_result(KIND_TEXT, b, REPLY_NONE, 8'd0, 1'b0, 8'd0);
                end
            end
            LP_CK_HI: begin
                v = hex_nibble(b);
                if (v < 0) begin
                    rx_fault = 1'b1;
                    v        = 0;
                end
                rx_high_nibble = 4'(v);
                rx_phase       = LP_CK_LO;
            end
            LP_CK_LO: begin
                v = hex_nibble(b);
                if (v < 0) begin
                    rx_fault = 1'b1;
                    v        = 0;
                end
                if ({rx_high_nibble, 4'(v)} != rx_sum) rx_fault = 1'b1;
                rx_phase = LP_CR;
            end
            LP_CR: begin
                if (b != CH_CR) rx_fault = 1'b1;
                rx_phase = LP_LF;
            end
            default: begin
                if (b != CH_LF) rx_fault = 1'b1;
                if (!rx_fault) begin
                    rx_bad_frames = 4'd0;
                    rx_phase      = LP_WAIT_STX;
                    queue_result(KIND_GOOD, 8'd0, REPLY_ACK, rx_frame_num,
                                 rx_ended_etx, rx_sum);
                end else begin
                    if (rx_bad_frames < BAD_COUNT_MAX) rx_bad_frames = rx_bad_frames + 4'd1;
                    // A limit of zero aborts on the first bad frame, like a limit of one.
                    if (rx_bad_frames >= retry_limit) begin
                        rx_bad_frames = 4'd0;
                        rx_phase      = LP_IDLE;
                        queue_result(KIND_ABORT, 8'd0, REPLY_NAK, rx_frame_num,
                                     rx_ended_etx, rx_sum);
                    end else begin
                        rx_phase = LP_WAIT_STX;
                        queue_result(KIND_BAD, 8'd0, REPLY_NAK, rx_frame_num,
                                     rx_ended_etx, rx_sum);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random or held-off ready, and the field-by-field check.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got kind %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                check_field("result_kind",  8'(want.kind),         8'(m_axis_tuser));
                check_field("text_byte",    want.text_byte,        m_axis_tdata[7:0]);
                check_field("reply_code",   8'(want.reply_code),   8'(m_axis_tdata[9:8]));
                check_field("frame_digit",  want.frame_digit,      m_axis_tdata[17:10]);
                check_field("final_frame",  8'(want.final_frame),  8'(m_axis_tdata[18]));
                check_field("sum_computed", want.sum_computed,     m_axis_tdata[26:19]);
                check_field("tdata padding", 8'd0,                 8'(m_axis_tdata[31:27]));
            end
        end
    end

    // The run ends here once the cycle count passes the overall limit, which also catches a stuck block.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Every task here is entered right after a rising edge.
    // ------------------------------------------------------------------------

    // Offers one byte after a random gap and returns at the edge where it is
    // taken. Valid stays high so that back-to-back items need no re-raise.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_link_step(b);
        bytes_sent++;
    endtask

    // Stops sending until every predicted result has come out, then lets
    // bytes that cause no result clear the pipeline.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    // Writes both registers while the block is quiet.
    task automatic reconfigure(input logic [3:0] retry, input logic [7:0] text_max);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RETRY_LIMIT;
        i_cfg_data <= {4'd0, retry};
        @(posedge i_clk);
        retry_limit = retry;
        i_cfg_idx  <= CFG_MAX_TEXT_LEN;
        i_cfg_data <= text_max;
        @(posedge i_clk);
        max_text_len = text_max;
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
        return b;
    endfunction

    // Text bytes lean toward control characters, which must pass as text.
    function automatic logic [7:0] text_byte_pick();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0:       b = CH_STX;
                1:       b = CH_EOT;
                2:       b = CH_ENQ;
                3:       b = CH_CR;
                default: b = CH_LF;
            endcase
        end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_ETX || b == CH_ETB);
        end
        return b;
    endfunction

    function automatic t_byte_q random_text(input int unsigned len);
        t_byte_q q;
        for (int unsigned i = 0; i < len; i++) q.push_back(text_byte_pick());
        return q;
    endfunction

    // Sends a whole frame with a correct two-digit checksum unless a flaw
    // is asked for.
    task automatic send_frame(input logic [7:0] fnum, input t_byte_q text,
                              input logic use_etx, input t_frame_flaw flaw);
        logic [7:0] sum;
        logic [7:0] term;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        sum  = fnum;
        term = use_etx ? CH_ETX : CH_ETB;
        send_byte(CH_STX);
        send_byte(fnum);
        foreach (text[i]) begin
            sum = sum + text[i];
            send_byte(text[i]);
        end
        sum = sum + term;
        send_byte(term);
        if (flaw == FLAW_SUM) sum = sum ^ 8'($urandom_range(1, 255));
        hi_c = (flaw == FLAW_DIGIT_HI) ? non_hex_byte() : hex_char(sum[7:4]);
        lo_c = (flaw == FLAW_DIGIT_LO) ? non_hex_byte() : hex_char(sum[3:0]);
        send_byte(hi_c);
        send_byte(lo_c);
        send_byte((flaw == FLAW_CR) ? byte_other_than(CH_CR) : CH_CR);
        send_byte((flaw == FLAW_LF) ? byte_other_than(CH_LF) : CH_LF);
    endtask

    // One random session: mostly ENQ, a few frames and EOT, sometimes just
    // a burst of noise heavy in control characters.
    task automatic send_session();
        int unsigned n_frames;
        int unsigned len;
        t_frame_flaw flaw;
        logic [7:0]  fnum;
        logic [7:0]  b;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 13))
                    0:       b = CH_STX;
                    1:       b = CH_ETX;
                    2:       b = CH_EOT;
                    3:       b = CH_ENQ;
                    4:       b = CH_LF;
                    5:       b = CH_CR;
                    6:       b = CH_ETB;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b);
            end
        end else begin
            send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_ENQ);
            n_frames = $urandom_range(1, 6);
            repeat (n_frames) begin
                if ($urandom_range(0, 9) == 0) send_byte(byte_other_than(CH_STX));
                if (max_text_len <= 16 && $urandom_range(0, 9) == 0)
                    len = max_text_len + $urandom_range(0, 2);
                else if ($urandom_range(0, 99) == 0)
                    len = max_text_len + $urandom_range(0, 1);
                else
                    len = $urandom_range(0, 8);
                flaw = ($urandom_range(0, 3) == 0) ? t_frame_flaw'($urandom_range(1, 5))
                                                   : FLAW_NONE;
                fnum = ($urandom_range(0, 9) < 7) ? 8'h30 + 8'($urandom_range(0, 7))
                                                  : 8'($urandom_range(0, 255));
                send_frame(fnum, random_text(len), 1'($urandom_range(0, 1)), flaw);
            end
            if ($urandom_range(0, 7) != 0) send_byte(CH_EOT);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Idle replies, entry into transfer, noise while waiting for STX, and
    // the end of a message.
    task automatic test_link_handshake();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_ENQ);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(CH_EOT);
        send_byte(CH_EOT);
        send_byte(CH_ENQ);
    endtask

    // Good frames with both terminators, control bytes in the text, extreme
    // frame numbers, a checksum below 0x10, and every kind of broken frame.
    task automatic test_frame_formats();
        t_byte_q text;
        text = '{CH_STX, CH_EOT, CH_CR, CH_LF};
        send_frame(8'h31, text, 1'b0, FLAW_NONE);
        text = {};
        send_frame(8'h00, text, 1'b1, FLAW_NONE);
        text = '{8'h00, 8'hFF};
        send_frame(8'hFF, text, 1'b1, FLAW_NONE);
        text = '{8'h41};
        send_frame(8'h32, text, 1'b1, FLAW_SUM);
        send_frame(8'h32, text, 1'b0, FLAW_DIGIT_HI);
        send_frame(8'h32, text, 1'b1, FLAW_NONE);
        send_frame(8'h33, text, 1'b1, FLAW_DIGIT_LO);
        send_frame(8'h33, text, 1'b0, FLAW_CR);
        send_frame(8'h33, text, 1'b1, FLAW_LF);
        send_byte(CH_EOT);
    endtask

    // Text right at the limit passes; longer text is dropped and the frame fails.
    task automatic test_text_limit();
        reconfigure(RETRY_LIMIT_RST, 8'd1);
        send_byte(CH_ENQ);
        send_frame(8'h31, random_text(1), 1'b1, FLAW_NONE);
        send_frame(8'h32, random_text(3), 1'b1, FLAW_NONE);
        send_byte(CH_EOT);
        reconfigure(RETRY_LIMIT_RST, 8'd16);
        send_byte(CH_ENQ);
        send_frame(8'h33, random_text(16), 1'b0, FLAW_NONE);
        send_frame(8'h34, random_text(17), 1'b1, FLAW_NONE);
        send_byte(CH_EOT);
    endtask

    // Abort after consecutive bad frames, including a zero limit and the
    // highest limit, and the count clearing on a good frame or a new ENQ.
    task automatic test_retry_limit();
        t_byte_q text;
        text = '{8'h52};
        reconfigure(4'd1, MAX_TEXT_LEN_RST);
        send_byte(CH_ENQ);
        send_frame(8'h31, text, 1'b1, FLAW_SUM);
        send_byte(8'h20);
        reconfigure(4'd0, MAX_TEXT_LEN_RST);
        send_byte(CH_ENQ);
        send_frame(8'h31, text, 1'b1, FLAW_CR);
        reconfigure(4'd2, MAX_TEXT_LEN_RST);
        send_byte(CH_ENQ);
        send_frame(8'h31, text, 1'b1, FLAW_SUM);
        send_frame(8'h32, text, 1'b1, FLAW_NONE);
        send_frame(8'h33, text, 1'b1, FLAW_LF);
        send_frame(8'h34, text, 1'b1, FLAW_DIGIT_HI);
        reconfigure(4'd3, MAX_TEXT_LEN_RST);
        send_byte(CH_ENQ);
        send_frame(8'h31, text, 1'b1, FLAW_SUM);
        send_frame(8'h32, text, 1'b1, FLAW_SUM);
        send_byte(CH_EOT);
        send_byte(CH_ENQ);
        send_frame(8'h33, text, 1'b1, FLAW_SUM);
        send_frame(8'h34, text, 1'b1, FLAW_SUM);
        send_byte(CH_EOT);
        reconfigure(4'd15, MAX_TEXT_LEN_RST);
        send_byte(CH_ENQ);
        repeat (15) send_frame(8'h35, text, 1'b0,
                               t_frame_flaw'($urandom_range(1, 5)));
        send_byte(8'h00);
    endtask

    // The result side holds off for a long stretch while text keeps coming,
    // so the block fills and stalls its input; then the sender waits it out.
    task automatic test_backpressure();
        reconfigure(RETRY_LIMIT_RST, MAX_TEXT_LEN_RST);
        idle_pct  = 0;
        stall_pct = 0;
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        @(posedge i_clk);
        send_byte(CH_ENQ);
        send_frame(8'h37, random_text(40), 1'b1, FLAW_NONE);
        wait_for_results();
        send_byte(CH_EOT);
    endtask

    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                       input logic [3:0] retry, input logic [7:0] text_max);
        int unsigned stop_at;
        reconfigure(retry, text_max);
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) send_session();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_link_handshake();
        test_frame_formats();
        test_text_limit();
        test_retry_limit();
        test_backpressure();

        // Random sessions under each idle and stall mix, with the register extremes.
        test_random_traffic(0, 0, RETRY_LIMIT_RST, MAX_TEXT_LEN_RST);
        test_random_traffic(83, 0, 4'd15, 8'd1);
        test_random_traffic(0, 83, 4'd1, 8'd8);
        test_random_traffic(13, 13, 4'($urandom_range(2, 6)), 8'($urandom_range(2, 20)));

        wait_for_results();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/afr_pkg.sv
src/afr_step.sv
src/afr_out_reg.sv
src/astm_frame_receiver_unit.sv
test/tb.sv
